// ----- rtl/hdf_pkg.sv -----
// Shared types, constants and helper functions for the header/terminator deframer.
package hdf_pkg;

   // Payload buffer size and the hard ceiling on the length limit.
   localparam int MAX_PAYLOAD   = 20;
   localparam int LIMIT_CEILING = 20;

   // Derived widths for the payload ring buffer.
   localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam int SUM_W = CNT_W + 1;

   // Field widths of the request and result items.
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 5;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register file geometry and reset values.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [BYTE_W-1:0] HEADER_RESET     = 8'hFA;
   localparam logic [BYTE_W-1:0] TERMINATOR_RESET = 8'h0A;
   localparam logic [LEN_W-1:0]  LIMIT_RESET      = 5'd20;

   // Register indexes.
   typedef enum logic [1:0] {
      CSR_HEADER     = 2'd0,
      CSR_TERMINATOR = 2'd1,
      CSR_LIMIT      = 2'd2
   } csr_reg_type;

   // Current register contents, seen by the front and the back.
   typedef struct packed {
      logic [BYTE_W-1:0] header;
      logic [BYTE_W-1:0] terminator;
      logic [LEN_W-1:0]  limit;
   } csr_type;

   // One classified byte waiting in the queue.
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              is_header;
      logic              is_terminator;
   } rx_item_type;

   // States of the back-end sequencer.
   typedef enum logic [2:0] {
      ST_HUNT,
      ST_COLLECT,
      ST_SCAN_ADDR,
      ST_SCAN_TEST,
      ST_EMIT_ADDR,
      ST_EMIT_OUT,
      ST_EMIT_EMPTY
   } back_state_type;

   // Clamp the programmed limit to the range 1 .. min(ceiling, buffer size).
   function automatic logic [CNT_W-1:0] eff_limit(input logic [LEN_W-1:0] lim);
      int v;
      v = int'(lim);
      if (v == 0) v = 1;
      if (v > LIMIT_CEILING) v = LIMIT_CEILING;
      if (v > MAX_PAYLOAD) v = MAX_PAYLOAD;
      return CNT_W'(v);
   endfunction

   // Ring buffer address of entry offset past head.
   function automatic logic [IDX_W-1:0] ring_ptr(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] offset);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(offset);
      if (sum >= SUM_W'(MAX_PAYLOAD)) sum = sum - SUM_W'(MAX_PAYLOAD);
      return IDX_W'(sum);
   endfunction

endpackage

// ----- rtl/hdf_ifs.sv -----
// Valid/ready channel interfaces for received bytes and deframed results.
interface hdf_req_if;
   import hdf_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface hdf_rsp_if;
   import hdf_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] payload_byte;
   logic [LEN_W-1:0]  frame_length;
   logic              is_last;
   logic              empty_frame;

   modport source (output valid, output payload_byte, output frame_length,
                   output is_last, output empty_frame, input ready);
   modport sink (input valid, input payload_byte, input frame_length,
                 input is_last, input empty_frame, output ready);
endinterface

// ----- rtl/header_terminator_deframer.sv -----
// Header/terminator byte deframer: configuration registers and the front/back pair.
//
// Received bytes enter a four-entry queue at up to one a cycle; the back end takes one
// queued byte a cycle while hunting for the header or collecting payload. After a
// terminator the first payload byte, if any, is read from the ring buffer, then the frame
// leaves at one result a cycle while the result register drains (n results for n payload
// bytes, or one result flagged empty_frame). When the payload count reaches the length
// limit the header is dropped and the buffered bytes are rescanned for a new header
// through the buffer's single read port: a setup state fetches the first byte, then each
// buffered byte is examined in turn. Bytes that arrive meanwhile wait in the queue, and
// ready falls only when it is full. Registers sit at byte offsets 0x0 (header_byte,
// reset 0xFA), 0x4 (terminator_byte, reset 0x0A) and 0x8 (length_limit, 5 bits, reset 20;
// 0 acts as 1, values above 20 act as 20); writes elsewhere are ignored and read back as zero.
module header_terminator_deframer (
   input  logic                             clock,
   input  logic                             reset,
   hdf_req_if.sink                          req_chan,
   hdf_rsp_if.source                        rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [hdf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [hdf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [hdf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import hdf_pkg::*;

   logic [BYTE_W-1:0] header_ff;
   logic [BYTE_W-1:0] terminator_ff;
   logic [LEN_W-1:0]  limit_ff;
   csr_reg_type       csr_index;
   logic              csr_write;
   csr_type           csr;
   rx_item_type       q_item;
   logic              q_valid;
   logic              q_pop;

   // Register decode.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff     <= HEADER_RESET;
         terminator_ff <= TERMINATOR_RESET;
         limit_ff      <= LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_HEADER:     header_ff     <= csr_pwdata[BYTE_W-1:0];
            CSR_TERMINATOR: terminator_ff <= csr_pwdata[BYTE_W-1:0];
            CSR_LIMIT:      limit_ff      <= csr_pwdata[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_index)
         CSR_HEADER:     csr_prdata = CSR_DATA_W'(header_ff);
         CSR_TERMINATOR: csr_prdata = CSR_DATA_W'(terminator_ff);
         CSR_LIMIT:      csr_prdata = CSR_DATA_W'(limit_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign csr.header     = header_ff;
   assign csr.terminator = terminator_ff;
   assign csr.limit      = limit_ff;

   // Front end: accept, classify and queue received bytes.
   hdf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .csr      (csr),
      .q_item   (q_item),
      .q_valid  (q_valid),
      .q_pop    (q_pop)
   );

   // Back end: frame sequencing, payload buffer and results.
   hdf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr),
      .q_item   (q_item),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- rtl/hdf_front.sv -----
// Front end: accepts received bytes, tags header/terminator matches and queues them.
module hdf_front (
   input  logic                 clock,
   input  logic                 reset,
   hdf_req_if.sink              req_chan,
   input  hdf_pkg::csr_type     csr,
   output hdf_pkg::rx_item_type q_item,
   output logic                 q_valid,
   input  logic                 q_pop
);
   import hdf_pkg::*;

   rx_item_type       queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;
   logic              push;
   logic              pop;
   rx_item_type       new_item;

   // Classify the incoming byte against the programmed header and terminator.
   always_comb begin
      new_item.data          = req_chan.rx_byte;
      new_item.is_header     = (req_chan.rx_byte == csr.header);
      new_item.is_terminator = (req_chan.rx_byte == csr.terminator);
   end

   // Handshake and queue bookkeeping.
   assign req_chan.ready = (fill_ff != QCNT_W'(QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign q_valid        = (fill_ff != '0);
   assign pop            = q_pop && q_valid;
   assign q_item         = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   // Queue pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

   // The fill level never passes the queue depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill level exceeds depth");

endmodule

// ----- rtl/hdf_back.sv -----
// Back end: frame sequencer with the payload ring buffer and the result register.
module hdf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  hdf_pkg::csr_type     csr,
   input  hdf_pkg::rx_item_type q_item,
   input  logic                 q_valid,
   output logic                 q_pop,
   hdf_rsp_if.source            rsp_chan
);
   import hdf_pkg::*;

   back_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [IDX_W-1:0]  head_ff, head_in;

   logic [BYTE_W-1:0] store_mem [MAX_PAYLOAD];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  wr_addr;
   logic              wr_en;

   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic [LEN_W-1:0]  rsp_len_ff;
   logic              rsp_last_ff;
   logic              rsp_empty_ff;

   logic              load;
   logic [BYTE_W-1:0] load_byte;
   logic [LEN_W-1:0]  load_len;
   logic              load_last;
   logic              load_empty;

   logic              slot_free;
   logic [CNT_W-1:0]  lim;
   logic [SUM_W-1:0]  count_inc;
   logic [CNT_W-1:0]  k_next;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign lim       = eff_limit(csr.limit);
   assign count_inc = SUM_W'(count_ff) + 1'b1;
   assign k_next    = k_ff + 1'b1;

   // Next state, buffer accesses and result loads.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      k_in       = k_ff;
      head_in    = head_ff;
      q_pop      = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = ring_ptr(head_ff, count_ff);
      rd_addr    = ring_ptr(head_ff, k_ff);
      load       = 1'b0;
      load_byte  = rd_data_ff;
      load_len   = LEN_W'(count_ff);
      load_last  = (k_next == count_ff);
      load_empty = 1'b0;
      case (state_ff)
         ST_HUNT: begin
            // Drop bytes until a header shows up.
            q_pop = 1'b1;
            if (q_valid && q_item.is_header) begin
               state_in = ST_COLLECT;
               count_in = '0;
            end
         end
         ST_COLLECT: begin
            // The terminator test wins over storing the byte.
            q_pop = 1'b1;
            if (q_valid) begin
               if (q_item.is_terminator) begin
                  k_in     = '0;
                  state_in = (count_ff == '0) ? ST_EMIT_EMPTY : ST_EMIT_ADDR;
               end else begin
                  wr_en    = 1'b1;
                  count_in = CNT_W'(count_inc);
                  if (count_inc >= SUM_W'(lim)) begin
                     k_in     = '0;
                     state_in = ST_SCAN_ADDR;
                  end
               end
            end
         end
         ST_SCAN_ADDR: begin
            // Fetch the first buffered byte for the rescan.
            state_in = ST_SCAN_TEST;
         end
         ST_SCAN_TEST: begin
            // Look for a header among the buffered bytes, one entry a cycle.
            rd_addr = ring_ptr(head_ff, k_next);
            if (rd_data_ff == csr.header) begin
               head_in  = ring_ptr(head_ff, k_next);
               count_in = count_ff - k_next;
               state_in = ST_COLLECT;
            end else if (k_next == count_ff) begin
               count_in = '0;
               state_in = ST_HUNT;
            end else begin
               k_in = k_next;
            end
         end
         ST_EMIT_ADDR: begin
            // Fetch the first payload byte of the frame.
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            // One result a cycle while the output register drains.
            if (slot_free) begin
               load    = 1'b1;
               rd_addr = ring_ptr(head_ff, k_next);
               if (load_last) begin
                  count_in = '0;
                  state_in = ST_HUNT;
               end else begin
                  k_in = k_next;
               end
            end
         end
         ST_EMIT_EMPTY: begin
            // A header followed directly by the terminator.
            if (slot_free) begin
               load       = 1'b1;
               load_byte  = '0;
               load_len   = '0;
               load_last  = 1'b1;
               load_empty = 1'b1;
               count_in   = '0;
               state_in   = ST_HUNT;
            end
         end
         default: begin
            state_in = ST_HUNT;
            count_in = '0;
         end
      endcase
   end

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
         count_ff <= '0;
         k_ff     <= '0;
         head_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         k_ff     <= k_in;
         head_ff  <= head_in;
      end
   end

   // Payload ring buffer with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= q_item.data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_byte_ff  <= load_byte;
         rsp_len_ff   <= load_len;
         rsp_last_ff  <= load_last;
         rsp_empty_ff <= load_empty;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.payload_byte = rsp_byte_ff;
   assign rsp_chan.frame_length = rsp_len_ff;
   assign rsp_chan.is_last      = rsp_last_ff;
   assign rsp_chan.empty_frame  = rsp_empty_ff;

   // The buffer never holds more bytes than it has entries.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PAYLOAD))
      else $error("payload count exceeds buffer size");

   // An empty-frame result is always a lone, zero-length result.
   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_last_ff && rsp_len_ff == '0))
      else $error("empty-frame result is malformed");

   // Hunting starts with an empty buffer.
   a_hunt_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HUNT) |-> (count_ff == '0))
      else $error("buffer not empty while hunting");

   // The rescan and emit index stays inside the buffered payload.
   a_scan_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_TEST || state_ff == ST_EMIT_OUT) |-> (k_ff < count_ff))
      else $error("scan or emit index out of range");

endmodule
